@@ hdl/fcrc_pkg.sv @@
`default_nettype none

package fcrc_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_SHORT    = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] data_word;
        logic        last_word;
    } in_beat_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] computed_crc;
        logic [31:0] received_crc;
    } out_beat_t;

    // one byte of the reflected crc, bitwise over the low byte
    function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = {24'd0, crc[7:0] ^ data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return {8'd0, crc[31:8]} ^ c;
    endfunction

    // high byte first, then low byte
    function automatic logic [31:0] fold_word(input logic [31:0] crc, input logic [15:0] word);
        logic [31:0] mid;
        mid = fold_byte(crc, word[15:8]);
        return fold_byte(mid, word[7:0]);
    endfunction

endpackage

`default_nettype wire

@@ hdl/frame_crc32_word_checker.sv @@
// channel | beat type             | handshake              | moves
// --------+-----------------------+------------------------+-------------------------------
// in      | fcrc_pkg::in_beat_t   | in_valid / in_ready    | one 16-bit frame word
// out     | fcrc_pkg::out_beat_t  | out_valid / out_ready  | one verdict per last word
//
// one word per clock sustained, unless a last word waits for room for its verdict; a verdict
// passes the input register, then crc fold and compare into the output register
// the path that sets the clock is two byte folds of the crc plus a 32-bit compare
// rst_n clears all frame state: crc to all ones, no words held, both registers empty
// a stalled verdict holds a last word in the input register, and the input behind it; other words keep flowing
`default_nettype none

module frame_crc32_word_checker
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  fcrc_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output fcrc_pkg::out_beat_t out_data
);
    import fcrc_pkg::*;

    // input register
    logic        s1_valid_reg, s1_valid_next;
    in_beat_t    s1_beat_reg;

    // frame state
    logic [31:0] crc_reg, crc_next;
    logic [15:0] held_reg [2];
    logic [15:0] held_next [2];
    logic [1:0]  count_reg, count_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_beat_reg, out_beat_next;

    logic        out_free;
    logic        s1_fire;
    logic        in_fire;
    logic [31:0] crc_fold;
    logic [31:0] rx_crc;

    // the output register frees up when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;
    // a last word needs room for its verdict, any other word just moves on
    assign s1_fire  = s1_valid_reg && (!s1_beat_reg.last_word || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    assign crc_fold = fold_word(crc_reg, held_reg[0]);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // holdback and crc update, then the verdict on the last word
    always_comb
    begin
        crc_next     = crc_reg;
        held_next[0] = held_reg[0];
        held_next[1] = held_reg[1];
        count_next   = count_reg;
        rx_crc       = 32'd0;

        if (s1_fire)
        begin
            if (count_reg == 2'd2)
            begin
                // oldest held word is data: fold it in and shift the holdback
                crc_next     = crc_fold;
                held_next[0] = held_reg[1];
                held_next[1] = s1_beat_reg.data_word;
            end
            else
            begin
                held_next[count_reg[0]] = s1_beat_reg.data_word;
                count_next              = count_reg + 2'd1;
            end
        end

        rx_crc = {held_next[1], held_next[0]};

        out_beat_next  = out_beat_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (s1_fire && s1_beat_reg.last_word)
        begin
            out_valid_next = 1'b1;
            if (count_next != 2'd2)
            begin
                // single-word frame: nothing folded, no crc received
                out_beat_next.status       = STATUS_SHORT;
                out_beat_next.computed_crc = CRC_INIT;
                out_beat_next.received_crc = 32'd0;
            end
            else
            begin
                out_beat_next.status       = (rx_crc == crc_next) ? STATUS_OK : STATUS_MISMATCH;
                out_beat_next.computed_crc = crc_next;
                out_beat_next.received_crc = rx_crc;
            end
            // new frame starts from scratch
            crc_next     = CRC_INIT;
            held_next[0] = 16'd0;
            held_next[1] = 16'd0;
            count_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            crc_reg       <= CRC_INIT;
            held_reg[0]   <= 16'd0;
            held_reg[1]   <= 16'd0;
            count_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            crc_reg       <= crc_next;
            held_reg[0]   <= held_next[0];
            held_reg[1]   <= held_next[1];
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_beat_reg <= in_data;
        end
        out_beat_reg <= out_beat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

`ifndef ASSERT_OFF
    // holdback never counts past two words
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("held word count out of range");

    // a word that is not last always leaves at least one word held
    a_hold_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_beat_reg.last_word) |=> (count_reg != 2'd0))
        else $error("word lost from holdback");

    // a verdict resets the frame state
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_beat_reg.last_word) |=> (count_reg == 2'd0 && crc_reg == CRC_INIT))
        else $error("frame state not cleared after verdict");

    // short frame verdict carries the initial crc and nothing received
    a_short_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_beat_reg.status == STATUS_SHORT)
            |-> (out_beat_reg.computed_crc == CRC_INIT && out_beat_reg.received_crc == 32'd0))
        else $error("short frame verdict carries stale crc");
`endif

endmodule

`default_nettype wire

@@ test/frame_crc32_word_checker_test.sv @@
`timescale 1ns / 1ps

module frame_crc32_word_checker_test;

    import fcrc_pkg::*;

    // run shape
    localparam int ITEMS           = 1600;
    localparam int QUIET_TAIL      = 250;
    localparam int HOLD_OFF_AT     = 500;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_MAX      = 10;

    // how a directed row gets its word: typed in, or the low / high half of the frame crc
    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_CRC_LO,
        ROW_CRC_HI
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] word;
        logic        last;
        logic        fixed;
        out_beat_t   want;
    } row_t;

    // per accepted beat: whether the verdict is typed in rather than predicted
    typedef struct packed {
        logic      fixed;
        out_beat_t want;
    } beat_note_t;

    typedef enum logic [1:0] {
        FRAME_GOOD,
        FRAME_FLIPPED,
        FRAME_NOISE,
        FRAME_SHORT
    } frame_kind_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    frame_crc32_word_checker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // expected verdicts, oldest first, and notes for beats offered but not yet taken
    out_beat_t  verdict_q [$];
    beat_note_t note_q [$];
    row_t       dir_rows [$];

    // shadow of the checker's frame state
    logic [31:0] frame_crc = CRC_INIT;
    logic [15:0] held_old  = 16'h0000;
    logic [15:0] held_new  = 16'h0000;
    int          held_n    = 0;

    int   mismatches  = 0;
    int   beats_sent  = 0;
    int   cycle_count = 0;
    logic quiet_tail  = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // reflected crc-32, one bit at a time: high byte first, each byte lsb first
    function automatic logic [31:0] crc_fold_word(input logic [31:0] crc, input logic [15:0] w);
        logic [31:0] r;
        logic        fb;
        int          b;
        int          idx;
        r = crc;
        for (b = 0; b < 16; b++)
        begin
            idx = (b < 8) ? b + 8 : b - 8;
            fb  = r[0] ^ w[idx];
            r   = r >> 1;
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // advance the shadow state by one word; a last word yields the verdict
    task automatic predict_verdict(input in_beat_t b, output logic got, output out_beat_t v);
        logic [31:0] rx;
        got = 1'b0;
        v   = '0;
        // two-word holdback: a word is folded only once two newer words have shown up
        if (held_n >= 2)
        begin
            frame_crc = crc_fold_word(frame_crc, held_old);
            held_old  = held_new;
            held_new  = b.data_word;
        end
        else if (held_n == 1)
        begin
            held_new = b.data_word;
            held_n   = 2;
        end
        else
        begin
            held_old = b.data_word;
            held_n   = 1;
        end
        if (b.last_word)
        begin
            got = 1'b1;
            if (held_n < 2)
            begin
                // single-word frame, nothing folded, nothing received
                v.status       = STATUS_SHORT;
                v.computed_crc = CRC_INIT;
                v.received_crc = 32'h0000_0000;
            end
            else
            begin
                // older trailing word is the low half
                rx             = {held_new, held_old};
                v.status       = (rx == frame_crc) ? STATUS_OK : STATUS_MISMATCH;
                v.computed_crc = frame_crc;
                v.received_crc = rx;
            end
            frame_crc = CRC_INIT;
            held_old  = 16'h0000;
            held_new  = 16'h0000;
            held_n    = 0;
        end
    endtask

    // input and output monitor: predict on every taken beat, check every taken verdict
    always @(posedge clk)
    begin : monitor
        beat_note_t note;
        logic       got;
        out_beat_t  v;
        out_beat_t  want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                note = note_q.pop_front();
                predict_verdict(in_data, got, v);
                if (got)
                begin
                    verdict_q.push_back(note.fixed ? note.want : v);
                end
            end
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("unexpected verdict at cycle %0d: status %0d crc %h rx %h",
                                 cycle_count, out_data.status, out_data.computed_crc,
                                 out_data.received_crc);
                    end
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (out_data.status !== want.status ||
                        out_data.computed_crc !== want.computed_crc ||
                        out_data.received_crc !== want.received_crc)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("verdict mismatch at cycle %0d", cycle_count);
                            $display("  status   expected %0d actual %0d",
                                     want.status, out_data.status);
                            $display("  computed expected %h actual %h",
                                     want.computed_crc, out_data.computed_crc);
                            $display("  received expected %h actual %h",
                                     want.received_crc, out_data.received_crc);
                        end
                    end
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold-off so the block backs up, none at the tail
    initial
    begin : receiver
        logic held_off;
        held_off = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held_off && beats_sent >= HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // offer one beat and hold it until taken; called just after a rising edge
    task automatic send_beat(input logic [15:0] w, input logic last, input logic fixed,
                             input out_beat_t want);
        beat_note_t note;
        in_beat_t   b;
        quiet_tail = (beats_sent >= ITEMS - QUIET_TAIL);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        note.fixed = fixed;
        note.want  = want;
        note_q.push_back(note);
        b.data_word = w;
        b.last_word = last;
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
    endtask

    // one random frame: data words, then the crc as two trailing words, or a single word for a short frame
    task automatic send_frame(input frame_kind_t kind);
        logic [31:0] crc;
        logic [15:0] w;
        int          n_data;
        int          i;
        if (kind == FRAME_SHORT)
        begin
            send_beat(16'($urandom_range(0, 65535)), 1'b1, 1'b0, '0);
        end
        else
        begin
            // mostly short frames, now and then a longer one
            n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 48) : $urandom_range(0, 10);
            crc    = CRC_INIT;
            for (i = 0; i < n_data; i++)
            begin
                w   = 16'($urandom_range(0, 65535));
                crc = crc_fold_word(crc, w);
                send_beat(w, 1'b0, 1'b0, '0);
            end
            if (kind == FRAME_FLIPPED)
            begin
                crc = crc ^ (32'd1 << $urandom_range(0, 31));
            end
            else if (kind == FRAME_NOISE)
            begin
                crc = $urandom;
            end
            send_beat(crc[15:0], 1'b0, 1'b0, '0);
            send_beat(crc[31:16], 1'b1, 1'b0, '0);
        end
    endtask

    task automatic add_row(input row_kind_t kind, input logic [15:0] word, input logic last);
        row_t r;
        r.kind  = kind;
        r.word  = word;
        r.last  = last;
        r.fixed = 1'b0;
        r.want  = '0;
        dir_rows.push_back(r);
    endtask

    // last word of a frame whose verdict is known outright
    task automatic add_fixed(input logic [15:0] word, input status_t status,
                             input logic [31:0] computed, input logic [31:0] received);
        row_t r;
        r.kind              = ROW_WORD;
        r.word              = word;
        r.last              = 1'b1;
        r.fixed             = 1'b1;
        r.want.status       = status;
        r.want.computed_crc = computed;
        r.want.received_crc = received;
        dir_rows.push_back(r);
    endtask

    initial
    begin : stimulus
        logic [31:0] gen_crc;
        logic [15:0] w;
        int          pick;
        int          i;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;

        // single-word frames are too short
        add_fixed(16'h0000, STATUS_SHORT, CRC_INIT, 32'h0000_0000);
        add_fixed(16'hFFFF, STATUS_SHORT, CRC_INIT, 32'h0000_0000);
        // two-word frames: no data, crc stays at its start value
        add_row(ROW_WORD, 16'hFFFF, 1'b0);
        add_fixed(16'hFFFF, STATUS_OK, CRC_INIT, 32'hFFFF_FFFF);
        add_row(ROW_WORD, 16'h0000, 1'b0);
        add_fixed(16'h0000, STATUS_MISMATCH, CRC_INIT, 32'h0000_0000);
        add_row(ROW_WORD, 16'h1234, 1'b0);
        add_fixed(16'hABCD, STATUS_MISMATCH, CRC_INIT, 32'hABCD_1234);
        // data followed by its own crc
        add_row(ROW_WORD, 16'h0000, 1'b0);
        add_row(ROW_CRC_LO, 16'h0000, 1'b0);
        add_row(ROW_CRC_HI, 16'h0000, 1'b1);
        add_row(ROW_WORD, 16'hFFFF, 1'b0);
        add_row(ROW_WORD, 16'h8001, 1'b0);
        add_row(ROW_CRC_LO, 16'h0000, 1'b0);
        add_row(ROW_CRC_HI, 16'h0000, 1'b1);
        // data with a wrong crc
        add_row(ROW_WORD, 16'hA5A5, 1'b0);
        add_row(ROW_WORD, 16'h5A5A, 1'b0);
        add_row(ROW_WORD, 16'h0000, 1'b0);
        add_row(ROW_WORD, 16'hFFFF, 1'b1);
        // byte order check: single bits at the byte edges
        add_row(ROW_WORD, 16'h0001, 1'b0);
        add_row(ROW_WORD, 16'h0100, 1'b0);
        add_row(ROW_WORD, 16'h8000, 1'b0);
        add_row(ROW_CRC_LO, 16'h0000, 1'b0);
        add_row(ROW_CRC_HI, 16'h0000, 1'b1);
        // short frame right after a long one: state must have cleared
        add_fixed(16'h7FFF, STATUS_SHORT, CRC_INIT, 32'h0000_0000);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        gen_crc = CRC_INIT;
        for (i = 0; i < dir_rows.size(); i++)
        begin
            case (dir_rows[i].kind)
                ROW_CRC_LO: w = gen_crc[15:0];
                ROW_CRC_HI: w = gen_crc[31:16];
                default:
                begin
                    w       = dir_rows[i].word;
                    gen_crc = crc_fold_word(gen_crc, w);
                end
            endcase
            send_beat(w, dir_rows[i].last, dir_rows[i].fixed, dir_rows[i].want);
            if (dir_rows[i].last)
            begin
                gen_crc = CRC_INIT;
            end
        end

        // random part: mostly well-formed frames, some corrupted, some noise, some short
        while (beats_sent < ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                send_frame(FRAME_GOOD);
            end
            else if (pick < 16)
            begin
                send_frame(FRAME_FLIPPED);
            end
            else if (pick < 18)
            begin
                send_frame(FRAME_NOISE);
            end
            else
            begin
                send_frame(FRAME_SHORT);
            end
        end

        // drain: every frame ended with a last word, so every verdict must show up
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0 || note_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && verdict_q.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/fcrc_pkg.sv
hdl/frame_crc32_word_checker.sv
test/frame_crc32_word_checker_test.sv
